>>> design/tse_pkg.sv
// Shared constants, codes and types of the trigonometric and square-root evaluator.
`default_nettype none
package tse_pkg;

    localparam int FRAC_BITS  = 26;
    localparam int TOL_BITS   = 26;
    localparam int MAX_TERMS  = 32;
    localparam int MAX_NEWTON = 32;

    localparam int MAX_ITER = (MAX_TERMS > MAX_NEWTON) ? MAX_TERMS : MAX_NEWTON;
    localparam int CW       = $clog2(MAX_ITER + 1);
    localparam int KW       = $clog2(2 * MAX_TERMS + 2);
    localparam int DVW      = 2 * KW + 2;
    localparam int QW       = 32 + FRAC_BITS;
    localparam int XW       = 63 - FRAC_BITS;
    localparam int QCW      = $clog2(QW + 1);

    localparam logic [63:0] HALF  = 64'd1 << (FRAC_BITS - 1);
    localparam logic [QW-1:0] POS_Q = QW'(32'h7FFF_FFFF);
    localparam logic [QW-1:0] NEG_Q = QW'(32'h8000_0000);

    localparam logic [2:0] KIND_SIN  = 3'd0;
    localparam logic [2:0] KIND_COS  = 3'd1;
    localparam logic [2:0] KIND_TAN  = 3'd2;
    localparam logic [2:0] KIND_COT  = 3'd3;
    localparam logic [2:0] KIND_SQRT = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDEF = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic CFG_TERM_TOL = 1'b0;
    localparam logic CFG_ROOT_TOL = 1'b1;

    localparam logic [30:0] TERM_TOL_RESET = 31'd1;
    localparam logic [26:0] ROOT_TOL_RESET = 27'd67109;

    typedef struct packed {
        logic          start;
        logic [QW-1:0] num;
        logic [31:0]   den;
    } t_div_req;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic [QW-1:0] quo;
    } t_div_rsp;

    function automatic logic [DVW-1:0] d_of(input logic [KW-1:0] k);
        logic [DVW-1:0] a;
        logic [DVW-1:0] b;
        begin
            a = DVW'(k) + DVW'(1);
            b = DVW'(k) + DVW'(2);
            d_of = a * b;
        end
    endfunction

endpackage
`default_nettype wire

>>> design/tse_mul.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
`default_nettype none
module tse_mul
    import tse_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

>>> design/tse_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
`default_nettype none
module tse_div
    import tse_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic [31:0]    r_rem;
    logic [QW-1:0]  r_quo;
    logic [31:0]    r_den;
    logic [QCW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [32:0]    shifted;
    logic           fits;

    assign shifted = {r_rem, r_quo[QW-1]};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quo  <= i_req.num;
                r_rem  <= '0;
                r_den  <= i_req.den;
                r_cnt  <= QCW'(QW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? 32'(shifted - {1'b0, r_den}) : shifted[31:0];
                r_quo <= {r_quo[QW-2:0], fits};
                r_cnt <= r_cnt - QCW'(1);
                if (r_cnt == QCW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule
`default_nettype wire

>>> design/trig_and_sqrt_evaluator.sv
// Top level: sequencer that evaluates sine, cosine, tangent, cotangent and square root.
//
// An input transaction carries a kind and a signed Q5.26 operand; one output
// transaction returns the value and a status for each input. Configuration
// writes set the term tolerance (index 0) and the root tolerance (index 1)
// and are accepted only while the sequencer is idle.
// Each series term runs through the sequencing states and two passes of the
// shared 32 by 32 multiplier, then through the shared one-bit-per-cycle
// divider. Sine or cosine thus take one series after squaring the operand,
// tangent and cotangent two series plus a quotient. A square root takes one
// squaring on the multiplier and one division per Newton step.
// The input side is not ready while an item is in work or while a
// configuration write is offered. A finished result waits in the output
// register; the next item is taken meanwhile, and the sequencer holds its
// next result until the receiver takes the current one.
// Synchronous reset empties the output register, returns the sequencer to
// idle and restores the reset tolerances.
`default_nettype none
module trig_and_sqrt_evaluator
    import tse_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [31:0] i_operand,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [31:0] o_value,
    output logic      [1:0]  o_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_XSQ_MUL  = 5'd1;
    localparam logic [4:0] S_XSQ      = 5'd2;
    localparam logic [4:0] S_SER_INIT = 5'd3;
    localparam logic [4:0] S_SER_TEST = 5'd4;
    localparam logic [4:0] S_SER_M1   = 5'd5;
    localparam logic [4:0] S_SER_M2   = 5'd6;
    localparam logic [4:0] S_SER_DIV  = 5'd7;
    localparam logic [4:0] S_SER_END  = 5'd8;
    localparam logic [4:0] S_Q_START  = 5'd9;
    localparam logic [4:0] S_Q_DIV    = 5'd10;
    localparam logic [4:0] S_SQ_INIT  = 5'd11;
    localparam logic [4:0] S_SQ_TOL   = 5'd12;
    localparam logic [4:0] S_SQ_MUL   = 5'd13;
    localparam logic [4:0] S_SQ_TEST  = 5'd14;
    localparam logic [4:0] S_SQ_DIV   = 5'd15;
    localparam logic [4:0] S_DONE     = 5'd16;

    logic [4:0]    r_state;
    logic [2:0]    r_kind;
    logic [31:0]   r_x;
    logic          r_cos;
    logic          r_sat;
    logic          r_undef;
    logic [XW-1:0] r_xsq;
    logic [31:0]   r_mag;
    logic          r_neg;
    logic [KW-1:0] r_k;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_sum;
    logic [31:0]   r_s;
    logic [63:0]   r_lo;
    logic [31:0]   r_t;
    logic [63:0]   r_rtx;
    logic [31:0]   r_res;
    logic [30:0]   r_term_tol;
    logic [26:0]   r_root_tol;
    logic          r_out_valid;
    logic [31:0]   r_out_value;
    logic [1:0]    r_out_status;

    logic [31:0]    mul_a;
    logic [31:0]    mul_b;
    logic [63:0]    mul_p;
    t_div_req       div_req;
    t_div_rsp       div_rsp;

    logic [31:0]    ax;
    logic [DVW-1:0] d_val;
    logic [33:0]    sum_ext;
    logic [33:0]    mag_ext;
    logic [33:0]    sum_acc;
    logic [31:0]    sum_clamped;
    logic           sum_over;
    logic           ser_more;
    logic [63:0]    ser_m;
    logic [QW-1:0]  ser_num;
    logic [QW-1:0]  ser_lim;
    logic [31:0]    q_numer;
    logic [31:0]    q_denom;
    logic [31:0]    q_ua;
    logic [31:0]    q_ub;
    logic           q_neg;
    logic [QW-1:0]  q_lim;
    logic [QW-1:0]  q_num;
    logic [31:0]    q_mag;
    logic [XW-1:0]  sq;
    logic [XW-1:0]  ux_ext;
    logic [XW-1:0]  err;
    logic           sq_stop;
    logic [QW:0]    nt_sum;
    logic [QW-1:0]  nt;
    logic           out_free;

    tse_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    tse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign ax    = r_x[31] ? (~r_x + 32'd1) : r_x;
    assign d_val = d_of(r_k);

    assign sum_ext = {{2{r_sum[31]}}, r_sum};
    assign mag_ext = {2'b00, r_mag};
    assign sum_acc = r_neg ? (sum_ext - mag_ext) : (sum_ext + mag_ext);

    always_comb begin
        sum_over    = 1'b0;
        sum_clamped = sum_acc[31:0];
        if ($signed(sum_acc) > $signed(34'h0_7FFF_FFFF)) begin
            sum_over    = 1'b1;
            sum_clamped = 32'h7FFF_FFFF;
        end else if ($signed(sum_acc) < $signed(34'h3_8000_0000)) begin
            sum_over    = 1'b1;
            sum_clamped = 32'h8000_0000;
        end
    end

    assign ser_more = (r_cnt < CW'(MAX_TERMS)) && (r_mag > {1'b0, r_term_tol});
    assign ser_m    = (mul_p << (32 - FRAC_BITS)) + ((r_lo + HALF) >> FRAC_BITS);
    assign ser_num  = QW'(ser_m + (64'(d_val) >> 1));
    assign ser_lim  = r_neg ? POS_Q : NEG_Q;

    assign q_numer = (r_kind == KIND_TAN) ? r_s : r_sum;
    assign q_denom = (r_kind == KIND_TAN) ? r_sum : r_s;
    assign q_ua    = q_numer[31] ? (~q_numer + 32'd1) : q_numer;
    assign q_ub    = q_denom[31] ? (~q_denom + 32'd1) : q_denom;
    assign q_neg   = q_numer[31] ^ q_denom[31];
    assign q_lim   = q_neg ? NEG_Q : POS_Q;
    assign q_num   = (QW'(q_ua) << FRAC_BITS) + QW'(q_ub >> 1);
    assign q_mag   = (div_rsp.quo > q_lim) ? q_lim[31:0] : div_rsp.quo[31:0];

    assign sq      = XW'((mul_p + HALF) >> FRAC_BITS);
    assign ux_ext  = XW'(r_x);
    assign err     = (sq > ux_ext) ? (sq - ux_ext) : (ux_ext - sq);
    assign sq_stop = ((64'(err) << TOL_BITS) <= r_rtx) || (r_cnt >= CW'(MAX_NEWTON));
    assign nt_sum  = (QW+1)'(r_t) + {1'b0, div_rsp.quo} + (QW+1)'(1);
    assign nt      = nt_sum[QW:1];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_XSQ_MUL: begin
                mul_a = ax;
                mul_b = ax;
            end
            S_SER_TEST: begin
                mul_a = r_mag;
                mul_b = r_xsq[31:0];
            end
            S_SER_M1: begin
                mul_a = r_mag;
                mul_b = 32'(r_xsq[XW-1:32]);
            end
            S_SQ_INIT: begin
                mul_a = 32'(r_root_tol);
                mul_b = r_x;
            end
            S_SQ_MUL: begin
                mul_a = r_t;
                mul_b = r_t;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_req = '0;
        unique case (r_state)
            S_SER_M2: begin
                div_req.start = 1'b1;
                div_req.num   = ser_num;
                div_req.den   = 32'(d_val);
            end
            S_Q_START: begin
                div_req.start = (q_denom != 32'd0);
                div_req.num   = q_num;
                div_req.den   = q_ub;
            end
            S_SQ_TEST: begin
                div_req.start = !sq_stop;
                div_req.num   = QW'(r_x) << FRAC_BITS;
                div_req.den   = r_t;
            end
            default: div_req = '0;
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_term_tol  <= TERM_TOL_RESET;
            r_root_tol  <= ROOT_TOL_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_TERM_TOL: r_term_tol <= i_cfg_data[30:0];
                    CFG_ROOT_TOL: r_root_tol <= i_cfg_data[26:0];
                    default:      r_term_tol <= r_term_tol;
                endcase
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_kind  <= i_kind;
                        r_x     <= i_operand;
                        r_cos   <= (i_kind == KIND_COS);
                        r_sat   <= 1'b0;
                        r_undef <= 1'b0;
                        r_res   <= '0;
                        if (i_kind == KIND_SIN || i_kind == KIND_COS ||
                            i_kind == KIND_TAN || i_kind == KIND_COT) begin
                            r_state <= S_XSQ_MUL;
                        end else if (i_kind == KIND_SQRT) begin
                            if (i_operand[31]) begin
                                r_undef <= 1'b1;
                                r_state <= S_DONE;
                            end else if (i_operand == 32'd0) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_SQ_INIT;
                            end
                        end else begin
                            r_undef <= 1'b1;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_XSQ_MUL: r_state <= S_XSQ;
                S_XSQ: begin
                    r_xsq   <= XW'((mul_p + HALF) >> FRAC_BITS);
                    r_state <= S_SER_INIT;
                end
                S_SER_INIT: begin
                    if (r_cos) begin
                        r_mag <= 32'd1 << FRAC_BITS;
                        r_neg <= 1'b0;
                        r_k   <= '0;
                    end else begin
                        r_mag <= ax;
                        r_neg <= r_x[31];
                        r_k   <= KW'(1);
                    end
                    r_sum   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_SER_TEST;
                end
                S_SER_TEST: begin
                    if (ser_more) begin
                        r_sum   <= sum_clamped;
                        r_sat   <= r_sat | sum_over;
                        r_state <= S_SER_M1;
                    end else begin
                        r_state <= S_SER_END;
                    end
                end
                S_SER_M1: begin
                    r_lo    <= mul_p;
                    r_state <= S_SER_M2;
                end
                S_SER_M2: r_state <= S_SER_DIV;
                S_SER_DIV: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quo > ser_lim) begin
                            r_mag <= ser_lim[31:0];
                            r_sat <= 1'b1;
                        end else begin
                            r_mag <= div_rsp.quo[31:0];
                        end
                        r_neg   <= !r_neg;
                        r_k     <= r_k + KW'(2);
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_SER_TEST;
                    end
                end
                S_SER_END: begin
                    if (r_kind == KIND_SIN || r_kind == KIND_COS) begin
                        r_res   <= r_sum;
                        r_state <= S_DONE;
                    end else if (!r_cos) begin
                        r_s     <= r_sum;
                        r_cos   <= 1'b1;
                        r_state <= S_SER_INIT;
                    end else begin
                        r_state <= S_Q_START;
                    end
                end
                S_Q_START: begin
                    if (q_denom == 32'd0) begin
                        r_undef <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_Q_DIV;
                    end
                end
                S_Q_DIV: begin
                    if (div_rsp.done) begin
                        r_res   <= q_neg ? (~q_mag + 32'd1) : q_mag;
                        r_sat   <= r_sat | (div_rsp.quo > q_lim);
                        r_state <= S_DONE;
                    end
                end
                S_SQ_INIT: begin
                    r_t     <= r_x;
                    r_cnt   <= '0;
                    r_state <= S_SQ_TOL;
                end
                S_SQ_TOL: begin
                    r_rtx   <= mul_p;
                    r_state <= S_SQ_MUL;
                end
                S_SQ_MUL: r_state <= S_SQ_TEST;
                S_SQ_TEST: begin
                    if (sq_stop) begin
                        r_res   <= r_t;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SQ_DIV;
                    end
                end
                S_SQ_DIV: begin
                    if (div_rsp.done) begin
                        if (nt > POS_Q) begin
                            r_t   <= 32'h7FFF_FFFF;
                            r_sat <= 1'b1;
                        end else begin
                            r_t <= nt[31:0];
                        end
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_SQ_MUL;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_undef ? 32'd0 : r_res;
                        r_out_status <= r_undef ? ST_UNDEF : (r_sat ? ST_SAT : ST_OK);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_status    = r_out_status;
    assign o_cfg_ready = (r_state == S_IDLE);

`ifndef SYNTHESIS
    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !div_rsp.busy)
        else $error("Divider busy while the evaluator is idle.");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("Divider started while a division is in progress.");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_UNDEF) |-> (o_value == 32'd0))
        else $error("Undefined result carries a nonzero value.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_ITER))
        else $error("Iteration count exceeds its bound.");
`endif

endmodule
`default_nettype wire
